/* src/fnbc_pkg.sv */
// Package for the face normal and backface cull block: request types, pipeline
// payload structs and register indexes. Depends on nothing; used by every module.
`default_nettype none
package fnbc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CamX = 2'd0,
    CamY = 2'd1,
    CamZ = 2'd2
  } cfg_idx_e;

  localparam int unsigned RootW = 31;  // bits of floor(sqrt(S))
  localparam int unsigned QuoW  = 17;  // quotient bits of the normal division
  localparam int unsigned NumW  = 46;  // numerator width of the normal division

  typedef struct packed {
    logic signed [31:0] vertex_a_x;
    logic signed [31:0] vertex_a_y;
    logic signed [31:0] vertex_a_z;
    logic signed [31:0] vertex_b_x;
    logic signed [31:0] vertex_b_y;
    logic signed [31:0] vertex_b_z;
    logic signed [31:0] vertex_c_x;
    logic signed [31:0] vertex_c_y;
    logic signed [31:0] vertex_c_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               facing_away;
    logic               degenerate;
  } out_t;

  // Data that rides alongside the square root
  typedef struct packed {
    logic [2:0][29:0] q;
    logic [2:0]       neg;
    logic             degen;
    logic [2:0][32:0] diff;
  } side_t;

  typedef struct packed {
    logic [61:0]       rem;
    logic [RootW-1:0]  root;
    side_t             side;
  } sq_t;

  typedef struct packed {
    logic [2:0][NumW-1:0] rem;
    logic [2:0][QuoW-1:0] quo;
    logic [RootW-1:0]     den;
    logic [2:0]           neg;
    logic                 degen;
    logic [2:0][32:0]     diff;
  } div_t;

endpackage
`default_nettype wire

/* src/fnbc_front.sv */
// Front pipeline: edges, cross product, block scaling and sum of squares.
// Depends on fnbc_pkg.
`default_nettype none
module fnbc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire fnbc_pkg::in_t data_i,
  input  wire logic [31:0]   cam_x_i,
  input  wire logic [31:0]   cam_y_i,
  input  wire logic [31:0]   cam_z_i,
  output logic               valid_o,
  output fnbc_pkg::sq_t      data_o
);

  logic [7:0] v_q;

  logic signed [32:0] e1_d [3];
  logic signed [32:0] e2_d [3];
  logic signed [32:0] d_d  [3];
  logic signed [32:0] e1_q [3];
  logic signed [32:0] e2_q [3];
  logic signed [32:0] d1_q [3];
  logic signed [65:0] prod_q [6];
  logic signed [32:0] d2_q [3];
  logic signed [66:0] p_d [3];
  logic signed [66:0] p_q [3];
  logic signed [32:0] d3_q [3];
  logic [65:0]        mag_q [3];
  logic [2:0]         neg4_q;
  logic signed [32:0] d4_q [3];
  logic [65:0]        any_one;
  logic [6:0]         top_d;
  logic [65:0]        mag5_q [3];
  logic [6:0]         top_q;
  logic [2:0]         neg5_q;
  logic signed [32:0] d5_q [3];
  logic [95:0]        shifted [3];
  logic [29:0]        q6_q [3];
  logic               degen6_q;
  logic [2:0]         neg6_q;
  logic signed [32:0] d6_q [3];
  logic [59:0]        sqr_q [3];
  logic [29:0]        q7_q [3];
  logic               degen7_q;
  logic [2:0]         neg7_q;
  logic signed [32:0] d7_q [3];
  logic [61:0]        s_q;
  fnbc_pkg::side_t    side_q;

  // Form edges and the offset of A from the camera
  always_comb begin
    e1_d[0] = 33'(data_i.vertex_b_x) - 33'(data_i.vertex_a_x);
    e1_d[1] = 33'(data_i.vertex_b_y) - 33'(data_i.vertex_a_y);
    e1_d[2] = 33'(data_i.vertex_b_z) - 33'(data_i.vertex_a_z);
    e2_d[0] = 33'(data_i.vertex_c_x) - 33'(data_i.vertex_a_x);
    e2_d[1] = 33'(data_i.vertex_c_y) - 33'(data_i.vertex_a_y);
    e2_d[2] = 33'(data_i.vertex_c_z) - 33'(data_i.vertex_a_z);
    d_d[0]  = 33'(data_i.vertex_a_x) - 33'($signed(cam_x_i));
    d_d[1]  = 33'(data_i.vertex_a_y) - 33'($signed(cam_y_i));
    d_d[2]  = 33'(data_i.vertex_a_z) - 33'($signed(cam_z_i));
  end

  // Cross product differences, the leading one of the magnitudes and the scaling shift
  always_comb begin
    p_d[0] = 67'(prod_q[0]) - 67'(prod_q[1]);
    p_d[1] = 67'(prod_q[2]) - 67'(prod_q[3]);
    p_d[2] = 67'(prod_q[4]) - 67'(prod_q[5]);
    any_one = mag_q[0] | mag_q[1] | mag_q[2];
    top_d = '0;
    for (int i = 0; i < 66; i++) begin
      if (any_one[i]) begin
        top_d = 7'(i + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      shifted[i] = {mag5_q[i], 30'b0} >> top_q;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i]   <= e1_d[i];
        e2_q[i]   <= e2_d[i];
        d1_q[i]   <= d_d[i];
        d2_q[i]   <= d1_q[i];
        p_q[i]    <= p_d[i];
        d3_q[i]   <= d2_q[i];
        mag_q[i]  <= p_q[i][66] ? 66'(-p_q[i]) : 66'(p_q[i]);
        d4_q[i]   <= d3_q[i];
        mag5_q[i] <= mag_q[i];
        d5_q[i]   <= d4_q[i];
        q6_q[i]   <= shifted[i][29:0];
        d6_q[i]   <= d5_q[i];
        sqr_q[i]  <= q6_q[i] * q6_q[i];
        q7_q[i]   <= q6_q[i];
        d7_q[i]   <= d6_q[i];
        neg4_q[i] <= p_q[i][66];
        side_q.q[i]    <= q7_q[i];
        side_q.diff[i] <= d7_q[i];
      end
      prod_q[0] <= e1_q[1] * e2_q[2];
      prod_q[1] <= e1_q[2] * e2_q[1];
      prod_q[2] <= e1_q[2] * e2_q[0];
      prod_q[3] <= e1_q[0] * e2_q[2];
      prod_q[4] <= e1_q[0] * e2_q[1];
      prod_q[5] <= e1_q[1] * e2_q[0];
      top_q    <= top_d;
      neg5_q   <= neg4_q;
      neg6_q   <= neg5_q;
      degen6_q <= (top_q == 7'd0);
      neg7_q   <= neg6_q;
      degen7_q <= degen6_q;
      s_q <= 62'(sqr_q[0]) + 62'(sqr_q[1]) + 62'(sqr_q[2]);
      side_q.neg   <= neg7_q;
      side_q.degen <= degen7_q;
    end
  end

  assign valid_o     = v_q[7];
  assign data_o.rem  = s_q;
  assign data_o.root = '0;
  assign data_o.side = side_q;

endmodule
`default_nettype wire

/* src/fnbc_sqrt_stage.sv */
// One stage of the integer square root: settles one root bit.
// Depends on fnbc_pkg.
`default_nettype none
module fnbc_sqrt_stage #(
  parameter int unsigned Bit = 30
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire fnbc_pkg::sq_t data_i,
  output logic               valid_o,
  output fnbc_pkg::sq_t      data_o
);

  logic [63:0]   trial;
  logic          fits;
  fnbc_pkg::sq_t data_d;
  fnbc_pkg::sq_t data_q;
  logic          valid_q;

  // Try (root + 2^Bit)^2 against the remainder
  always_comb begin
    trial  = (64'(data_i.root) << (Bit + 1)) | (64'(1) << (2 * Bit));
    fits   = (64'(data_i.rem) >= trial);
    data_d = data_i;
    if (fits) begin
      data_d.rem  = 62'(64'(data_i.rem) - trial);
      data_d.root = data_i.root | (fnbc_pkg::RootW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* src/fnbc_div_stage.sv */
// One stage of the restoring division for all three normal lanes.
// Depends on fnbc_pkg.
`default_nettype none
module fnbc_div_stage #(
  parameter int unsigned Bit = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire fnbc_pkg::div_t data_i,
  output logic                valid_o,
  output fnbc_pkg::div_t      data_o
);

  logic [47:0]    dsh;
  fnbc_pkg::div_t data_d;
  fnbc_pkg::div_t data_q;
  logic           valid_q;

  // Subtract the shifted divisor where it fits and set the quotient bit
  always_comb begin
    dsh    = 48'(data_i.den) << Bit;
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      if (48'(data_i.rem[i]) >= dsh) begin
        data_d.rem[i] = fnbc_pkg::NumW'(48'(data_i.rem[i]) - dsh);
        data_d.quo[i] = data_i.quo[i] | (fnbc_pkg::QuoW'(1) << Bit);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* src/fnbc_back.sv */
// Back pipeline: clamp and sign the normal, dot with the view offset, flag.
// Depends on fnbc_pkg.
`default_nettype none
module fnbc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire fnbc_pkg::div_t data_i,
  output logic                valid_o,
  output fnbc_pkg::out_t      data_o
);

  logic [2:0]         v_q;
  logic signed [16:0] nrm_d [3];
  logic signed [16:0] nrm_q [3];
  logic signed [32:0] da_q [3];
  logic               degen_a_q;
  logic signed [49:0] prod_q [3];
  logic signed [16:0] nrm_b_q [3];
  logic               degen_b_q;
  logic signed [51:0] dot;
  fnbc_pkg::out_t     out_q;

  // Saturate the rounded quotient and apply the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_d[i] = '0;
      if (!data_i.degen) begin
        if (data_i.neg[i]) begin
          nrm_d[i] = (data_i.quo[i] > 17'd32768) ? -17'sd32768
                                                 : -$signed(data_i.quo[i]);
        end else begin
          nrm_d[i] = (data_i.quo[i] > 17'd32767) ? 17'sd32767
                                                 : $signed(data_i.quo[i]);
        end
      end
    end
    dot = 52'(prod_q[0]) + 52'(prod_q[1]) + 52'(prod_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        nrm_q[i]   <= nrm_d[i];
        da_q[i]    <= $signed(data_i.diff[i]);
        prod_q[i]  <= nrm_q[i] * da_q[i];
        nrm_b_q[i] <= nrm_q[i];
      end
      degen_a_q         <= data_i.degen;
      degen_b_q         <= degen_a_q;
      out_q.normal_x    <= nrm_b_q[0][15:0];
      out_q.normal_y    <= nrm_b_q[1][15:0];
      out_q.normal_z    <= nrm_b_q[2][15:0];
      out_q.facing_away <= !degen_b_q && !dot[51];
      out_q.degenerate  <= degen_b_q;
    end
  end

  assign valid_o = v_q[2];
  assign data_o  = out_q;

endmodule
`default_nettype wire

/* src/face_normal_backface_cull.sv */
// Triangle face normal and backface cull, top level.
// Depends on fnbc_pkg, fnbc_front, fnbc_sqrt_stage, fnbc_div_stage, fnbc_back.
//
// Usage: a triangle request (three Q16.16 vertices) is taken on the input
// channel when in_valid_i is high and in_stall_o is low. One result (Q1.15
// unit normal, facing_away, degenerate) leaves on the output channel when
// out_valid_o is high and out_stall_i is low. Camera registers are written
// over the cfg channel (always ready); write them only while idle.
// There are 8 front stages (edges, cross product, scaling, squares), 31
// square root stages (one root bit each), 17 division stages (one
// quotient bit each, three lanes) and 3 back stages. One triangle enters
// per cycle unless stalled. Reset zeroes all valid bits and the camera.
// While a result waits at the output under stall, the whole pipeline holds
// and in_stall_o is raised; nothing is dropped or repeated.
`default_nettype none
module face_normal_backface_cull (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire fnbc_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output fnbc_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i
);

  logic          en;
  logic [31:0]   cam_q [3];
  logic          sq_v [32];
  fnbc_pkg::sq_t sq_c [32];
  logic           dv_v [18];
  fnbc_pkg::div_t dv_c [18];

  // Hold the whole pipeline while the output request is stalled
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // Camera registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
    end else if (cfg_valid_i) begin
      case (fnbc_pkg::cfg_idx_e'(cfg_index_i))
        fnbc_pkg::CamX: cam_q[0] <= cfg_data_i;
        fnbc_pkg::CamY: cam_q[1] <= cfg_data_i;
        fnbc_pkg::CamZ: cam_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fnbc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cam_x_i (cam_q[0]),
    .cam_y_i (cam_q[1]),
    .cam_z_i (cam_q[2]),
    .valid_o (sq_v[0]),
    .data_o  (sq_c[0])
  );

  // Square root, most significant bit first
  for (genvar k = 0; k < 31; k++) begin : g_sqrt
    fnbc_sqrt_stage #(.Bit(30 - k)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[k]),
      .data_i  (sq_c[k]),
      .valid_o (sq_v[k+1]),
      .data_o  (sq_c[k+1])
    );
  end

  // Set up the rounded division by the length
  always_comb begin
    dv_v[0]       = sq_v[31];
    dv_c[0].den   = sq_c[31].root;
    dv_c[0].neg   = sq_c[31].side.neg;
    dv_c[0].degen = sq_c[31].side.degen;
    dv_c[0].diff  = sq_c[31].side.diff;
    for (int i = 0; i < 3; i++) begin
      dv_c[0].rem[i] = (fnbc_pkg::NumW'(sq_c[31].side.q[i]) << 15)
                     + fnbc_pkg::NumW'(sq_c[31].root >> 1);
      dv_c[0].quo[i] = '0;
    end
  end

  for (genvar k = 0; k < 17; k++) begin : g_div
    fnbc_div_stage #(.Bit(16 - k)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[k]),
      .data_i  (dv_c[k]),
      .valid_o (dv_v[k+1]),
      .data_o  (dv_c[k+1])
    );
  end

  fnbc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_v[17]),
    .data_i  (dv_c[17]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
`default_nettype wire
